[hw/rtl/x86_register_file_with_flags_top_macros.svh]
// Assertion macros for the register file and flag unit.
// Taken in by the top level; depends on nothing else.
`ifndef X86_REGISTER_FILE_WITH_FLAGS_TOP_MACROS_SVH
`define X86_REGISTER_FILE_WITH_FLAGS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define X86RF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("x86rf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define X86RF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("x86rf: next-cycle check failed");

`endif

[hw/rtl/x86rf_pkg.sv]
// Shared types and constants of the register file and flag unit.
// Used by the controller, the datapath and the top level.
`default_nettype none

package x86rf_pkg;

   localparam int NUM_REGS = 14;
   localparam int REG_IDX_W = 4;

   localparam logic [REG_IDX_W-1:0] REG_DX    = 4'd3;
   localparam logic [REG_IDX_W-1:0] REG_FLAGS = 4'd9;
   localparam logic [REG_IDX_W-1:0] REG_LAST  = 4'd13;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_UPDATE = 2'd2;

   localparam logic [1:0] PART_HIGH = 2'd0;
   localparam logic [1:0] PART_LOW  = 2'd1;
   localparam logic [1:0] PART_WORD = 2'd2;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;

   localparam logic [15:0] FLAGS_KEEP_MASK = 16'h0700;

   localparam int BIT_CF = 0;
   localparam int BIT_PF = 2;
   localparam int BIT_AF = 4;
   localparam int BIT_ZF = 6;
   localparam int BIT_SF = 7;
   localparam int BIT_OF = 11;

   typedef struct packed {
      logic [1:0]           mode;
      logic [REG_IDX_W-1:0] reg_index;
      logic [1:0]           part;
      logic [15:0]          write_value;
      logic [15:0]          operand_a;
      logic [15:0]          operand_b;
      logic [15:0]          op_result;
      logic [1:0]           arith_kind;
      logic                 wide;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        access_error;
      logic [15:0] flags_now;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic execute;
   } ctl_type;

endpackage

`default_nettype wire

[hw/rtl/x86rf_datapath.sv]
// Datapath: request register, the fourteen-entry register store, flag logic
// and the result register. Depends on x86rf_pkg.
`default_nettype none

module x86rf_datapath
   import x86rf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire ctl_type ctl,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   req_type     req_ff;
   logic [15:0] regs_ff [NUM_REGS];
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic        access_ok;
   logic [15:0] cur_word;
   logic [15:0] merged_word;
   logic [7:0]  sel_byte;
   logic [15:0] byte_ext;
   logic [15:0] upd_flags;
   logic [15:0] flags_after;
   logic        do_write;
   logic [15:0] chain_add;
   logic [15:0] chain_sub;
   logic [15:0] ovf_add;
   logic [15:0] ovf_sub;
   logic [15:0] chain;
   logic [15:0] ovf;
   logic        arith;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      access_ok = (req_ff.reg_index <= REG_LAST) && (req_ff.part <= PART_WORD)
         && ((req_ff.part == PART_WORD) || (req_ff.reg_index <= REG_DX)
            || (req_ff.reg_index == REG_FLAGS));
      cur_word = access_ok ? regs_ff[req_ff.reg_index] : 16'h0000;

      unique case (req_ff.part)
         PART_HIGH: merged_word = {req_ff.write_value[7:0], cur_word[7:0]};
         PART_LOW:  merged_word = {cur_word[15:8], req_ff.write_value[7:0]};
         default:   merged_word = req_ff.write_value;
      endcase

      sel_byte = (req_ff.part == PART_HIGH) ? cur_word[15:8] : cur_word[7:0];
      byte_ext = {{8{sel_byte[7]}}, sel_byte};
      do_write = (req_ff.mode == MODE_WRITE) && access_ok;
   end

   // Carry chains: bit n of the chain is the carry or borrow out of bit n.
   always_comb begin
      chain_add = (req_ff.operand_a & req_ff.operand_b)
         | ((req_ff.operand_a | req_ff.operand_b) & ~req_ff.op_result);
      chain_sub = (~req_ff.operand_a & req_ff.operand_b)
         | ((~req_ff.operand_a | req_ff.operand_b) & req_ff.op_result);
      ovf_add = (req_ff.operand_a ^ req_ff.op_result)
         & (req_ff.operand_b ^ req_ff.op_result);
      ovf_sub = (req_ff.operand_a ^ req_ff.operand_b)
         & (req_ff.operand_a ^ req_ff.op_result);
      arith = (req_ff.arith_kind == KIND_ADD) || (req_ff.arith_kind == KIND_SUB);
      chain = (req_ff.arith_kind == KIND_SUB) ? chain_sub : chain_add;
      ovf   = (req_ff.arith_kind == KIND_SUB) ? ovf_sub : ovf_add;

      upd_flags = regs_ff[REG_FLAGS] & FLAGS_KEEP_MASK;
      upd_flags[BIT_ZF] = req_ff.wide ? (req_ff.op_result == 16'h0000)
                                      : (req_ff.op_result[7:0] == 8'h00);
      upd_flags[BIT_SF] = req_ff.wide ? req_ff.op_result[15] : req_ff.op_result[7];
      upd_flags[BIT_PF] = ~^req_ff.op_result[7:0];
      upd_flags[BIT_CF] = arith && (req_ff.wide ? chain[15] : chain[7]);
      upd_flags[BIT_AF] = arith && chain[3];
      upd_flags[BIT_OF] = arith && (req_ff.wide ? ovf[15] : ovf[7]);
   end

   always_comb begin
      priority if (req_ff.mode == MODE_UPDATE) begin
         flags_after = upd_flags;
      end else if (do_write && (req_ff.reg_index == REG_FLAGS)) begin
         flags_after = merged_word;
      end else begin
         flags_after = regs_ff[REG_FLAGS];
      end

      rsp_in.flags_now    = flags_after;
      rsp_in.access_error = ((req_ff.mode == MODE_WRITE) || (req_ff.mode == MODE_READ))
                            && !access_ok;
      rsp_in.read_data    = 16'h0000;
      if ((req_ff.mode == MODE_READ) && access_ok) begin
         rsp_in.read_data = (req_ff.part == PART_WORD) ? cur_word : byte_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= 16'h0000;
         end
      end else if (ctl.execute) begin
         if (req_ff.mode == MODE_UPDATE) begin
            regs_ff[REG_FLAGS] <= upd_flags;
         end else if (do_write) begin
            regs_ff[req_ff.reg_index] <= merged_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/x86rf_controller.sv]
// Controller state machine: takes a request, runs its execute state and
// raises the result strobe. Depends on x86rf_pkg.
`default_nettype none

module x86rf_controller
   import x86rf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output ctl_type   ctl,
   output logic      rsp_valid
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.load     = 1'b0;
      ctl.execute  = 1'b0;
      busy         = 1'b0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.load = start;
         end
         ST_EXEC: begin
            busy         = 1'b1;
            ctl.execute  = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hw/rtl/x86_register_file_with_flags_top.sv]
// Top level of the 8086-style register file and flag unit.
// Depends on x86rf_pkg, x86rf_controller, x86rf_datapath and the macro header.
//
// A transaction is taken when start is high and busy is low. Each one
// produces exactly one result, shown on rsp_data for a single cycle with
// rsp_valid high and registered at the end of the execute cycle; the receiver
// cannot stall it. busy is high for the one execute cycle, in which the
// register store is read, the flag logic evaluated and any write done, so
// a new transaction may be issued as soon as busy is low again, including in the
// cycle in which the previous result is on the ports. The register store
// is all zero after reset.
`default_nettype none

`include "x86_register_file_with_flags_top_macros.svh"

module x86_register_file_with_flags_top
   import x86rf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   ctl_type ctl;

   x86rf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .ctl       (ctl),
      .rsp_valid (rsp_valid)
   );

   x86rf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // A taken transaction leads to the execute cycle, and that to the strobe.
   `X86RF_ASSERT_NEXT(a_accept_then_busy, clock, reset, start && !busy, busy)
   `X86RF_ASSERT_NEXT(a_busy_then_result, clock, reset, busy, rsp_valid && !busy)
   `X86RF_ASSERT_IMPL(a_result_follows_exec, clock, reset, rsp_valid, $past(busy))

endmodule

`default_nettype wire

[tb/tb_x86_register_file_with_flags_top.sv]
// Self-checking testbench for the 8086-style register file and flag unit.
// Depends on x86rf_pkg and x86_register_file_with_flags_top; drives directed and random
// register accesses and flag updates, and checks every result against its own register model.
module tb_x86_register_file_with_flags_top
   import x86rf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 1000;
   localparam int IDLE_LIMIT = 1000;
   localparam int TAIL_CYCLES = 4;
   localparam int REPORT_MAX = 10;

   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam logic [1:0] PART_BAD = 2'd3;
   localparam logic [1:0] KIND_LOGIC = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef enum logic [3:0] {
      R_AX, R_BX, R_CX, R_DX, R_SI, R_DI, R_BP, R_SP,
      R_IP, R_FLAGS, R_CS, R_DS, R_SS, R_ES, R_NONE14, R_NONE15
   } reg_name_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type     access_queue[$];
   rsp_type     pending_rsp[$];
   logic [15:0] reg_shadow[NUM_REGS];

   int n_sent = 0;
   int n_done = 0;
   int issued = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int n_writes = 0;
   int n_reads = 0;
   int n_updates = 0;
   int n_refused = 0;
   bit timed_out = 1'b0;

   x86_register_file_with_flags_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [15:0] flags_from_op(req_type t, logic [15:0] old_flags);
      logic [15:0] msk;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] r;
      logic [15:0] carries;
      logic [15:0] ovf;
      logic [15:0] f;
      int          top;
      msk = t.wide ? 16'hFFFF : 16'h00FF;
      top = t.wide ? 15 : 7;
      a = t.operand_a & msk;
      b = t.operand_b & msk;
      r = t.op_result & msk;
      f = old_flags & FLAGS_KEEP_MASK;
      f[BIT_ZF] = (r == 16'h0000);
      f[BIT_SF] = r[top];
      f[BIT_PF] = ~^r[7:0];
      if (t.arith_kind == KIND_ADD) begin
         carries = (a & b) | ((a | b) & ~r);
         ovf = (a ^ r) & (b ^ r);
      end else if (t.arith_kind == KIND_SUB) begin
         carries = (~a & b) | ((~a | b) & r);
         ovf = (a ^ b) & (a ^ r);
      end else begin
         carries = '0;
         ovf = '0;
      end
      f[BIT_CF] = carries[top];
      f[BIT_AF] = carries[3];
      f[BIT_OF] = ovf[top];
      return f;
   endfunction

   // Applies one transaction to the register model and returns the result it should give.
   function automatic rsp_type predict_access(req_type t);
      rsp_type     o;
      logic        ok;
      logic [15:0] cur;
      logic [7:0]  sel;
      o = '0;
      ok = (t.reg_index <= REG_LAST) && (t.part != PART_BAD) &&
           (t.part == PART_WORD || t.reg_index <= REG_DX || t.reg_index == REG_FLAGS);
      if (t.mode == MODE_WRITE || t.mode == MODE_READ) begin
         if (!ok) begin
            o.access_error = 1'b1;
         end else if (t.mode == MODE_WRITE) begin
            cur = reg_shadow[t.reg_index];
            case (t.part)
               PART_HIGH: cur[15:8] = t.write_value[7:0];
               PART_LOW:  cur[7:0] = t.write_value[7:0];
               default:   cur = t.write_value;
            endcase
            reg_shadow[t.reg_index] = cur;
         end else begin
            cur = reg_shadow[t.reg_index];
            if (t.part == PART_WORD) begin
               o.read_data = cur;
            end else begin
               sel = (t.part == PART_HIGH) ? cur[15:8] : cur[7:0];
               o.read_data = {{8{sel[7]}}, sel};
            end
         end
      end else if (t.mode == MODE_UPDATE) begin
         reg_shadow[REG_FLAGS] = flags_from_op(t, reg_shadow[REG_FLAGS]);
      end
      o.flags_now = reg_shadow[REG_FLAGS];
      return o;
   endfunction

   function automatic logic [15:0] corner_word();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return 16'h0080;
         default: return 16'h007F;
      endcase
   endfunction

   // Unused fields are random so that their bits toggle as well.
   function automatic req_type random_fill();
      req_type t;
      t.mode = 2'($urandom_range(3));
      t.reg_index = 4'($urandom_range(15));
      t.part = 2'($urandom_range(3));
      t.write_value = 16'($urandom);
      t.operand_a = 16'($urandom);
      t.operand_b = 16'($urandom);
      t.op_result = 16'($urandom);
      t.arith_kind = 2'($urandom_range(3));
      t.wide = 1'($urandom_range(1));
      return t;
   endfunction

   task automatic push_access(logic [1:0] mode, logic [3:0] idx, logic [1:0] part,
                              logic [15:0] value);
      req_type t;
      t = random_fill();
      t.mode = mode;
      t.reg_index = idx;
      t.part = part;
      t.write_value = value;
      access_queue.push_back(t);
   endtask

   task automatic push_update(logic [1:0] kind, logic wide, logic [15:0] a, logic [15:0] b,
                              logic [15:0] r);
      req_type t;
      t = random_fill();
      t.mode = MODE_UPDATE;
      t.arith_kind = kind;
      t.wide = wide;
      t.operand_a = a;
      t.operand_b = b;
      t.op_result = r;
      access_queue.push_back(t);
   endtask

   function automatic req_type random_req();
      req_type t;
      int      pick;
      t = random_fill();
      pick = $urandom_range(99);
      if (pick < 36)      t.mode = MODE_WRITE;
      else if (pick < 70) t.mode = MODE_READ;
      else if (pick < 95) t.mode = MODE_UPDATE;
      else                t.mode = MODE_NONE;
      pick = $urandom_range(99);
      if (pick < 45)      t.reg_index = 4'($urandom_range(3));
      else if (pick < 55) t.reg_index = REG_FLAGS;
      else if (pick < 92) t.reg_index = 4'($urandom_range(13));
      else                t.reg_index = 4'($urandom_range(15, 14));
      t.part = ($urandom_range(99) < 5) ? PART_BAD : 2'($urandom_range(2));
      if ($urandom_range(9) == 0) t.write_value = corner_word();
      if ($urandom_range(9) == 0) t.operand_a = corner_word();
      if ($urandom_range(9) == 0) t.operand_b = corner_word();
      // Most flag updates carry a result that matches their operands.
      if ($urandom_range(99) < 70) begin
         case (t.arith_kind)
            KIND_ADD: t.op_result = t.operand_a + t.operand_b;
            KIND_SUB: t.op_result = t.operand_a - t.operand_b;
            default:  t.op_result = t.operand_a ^ t.operand_b;
         endcase
      end
      return t;
   endfunction

   // Driver: offers queued transactions, with random gaps, when the block can accept one.
   always @(posedge clock) begin
      rsp_type want;
      int      left;
      int      idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            want = predict_access(req_data);
            pending_rsp.push_back(want);
            n_sent++;
            issued++;
            if (want.access_error)               n_refused++;
            else if (req_data.mode == MODE_WRITE)  n_writes++;
            else if (req_data.mode == MODE_READ)   n_reads++;
            else if (req_data.mode == MODE_UPDATE) n_updates++;
         end
         left = n_sent - n_done - (rsp_valid ? 1 : 0);
         if (issued < N_RANDOM / 3)          idle_pct = 6;
         else if (issued < 2 * N_RANDOM / 3) idle_pct = 83;
         else                                idle_pct = 0;
         if (access_queue.size() > 0 && !(issued % 100 == 50 && left != 0) &&
             $urandom_range(99) >= idle_pct) begin
            req_data <= access_queue.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
      end
   endtask

   // Monitor: every strobed result is matched with the oldest outstanding expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         n_done <= n_done + 1;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t ns: result %h arrived with no transaction outstanding",
                        $time, rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            check_field("read_data", want.read_data, rsp_data.read_data);
            check_field("access_error", 16'(want.access_error), 16'(rsp_data.access_error));
            check_field("flags_now", want.flags_now, rsp_data.flags_now);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else                                      idle_cycles <= idle_cycles + 1;
   end

   initial begin
      foreach (reg_shadow[i]) reg_shadow[i] = 16'h0000;

      // Byte and word access to the general registers, with sign extension on byte reads.
      push_access(MODE_WRITE, R_AX, PART_WORD, 16'hFFFF);
      push_access(MODE_READ, R_AX, PART_HIGH, 16'h0000);
      push_access(MODE_WRITE, R_AX, PART_LOW, 16'h017F);
      push_access(MODE_READ, R_AX, PART_LOW, 16'h0000);
      push_access(MODE_READ, R_AX, PART_WORD, 16'h0000);
      push_access(MODE_WRITE, R_BX, PART_HIGH, 16'hAB80);
      push_access(MODE_READ, R_BX, PART_HIGH, 16'h0000);
      push_access(MODE_WRITE, R_DX, PART_LOW, 16'h00FF);
      // Word access elsewhere is fine, byte access there is refused.
      push_access(MODE_WRITE, R_SI, PART_WORD, 16'h1234);
      push_access(MODE_READ, R_SI, PART_HIGH, 16'h0000);
      push_access(MODE_WRITE, R_DI, PART_LOW, 16'h5555);
      push_access(MODE_WRITE, R_ES, PART_WORD, 16'hFFFF);
      push_access(MODE_READ, R_ES, PART_WORD, 16'h0000);
      // Register numbers past the last one, a bad part code and the unused mode.
      push_access(MODE_WRITE, R_NONE14, PART_WORD, 16'hFFFF);
      push_access(MODE_READ, R_NONE15, PART_LOW, 16'h0000);
      push_access(MODE_READ, R_AX, PART_BAD, 16'h0000);
      push_access(MODE_NONE, R_AX, PART_WORD, 16'hFFFF);
      // FLAGS takes reserved bits as written; updates then keep only TF, IF and DF.
      push_access(MODE_WRITE, R_FLAGS, PART_WORD, 16'hFFFF);
      push_access(MODE_READ, R_FLAGS, PART_LOW, 16'h0000);
      push_update(KIND_ADD, 1'b1, 16'hFFFF, 16'h0001, 16'h0000);
      push_update(KIND_SUB, 1'b0, 16'h1280, 16'h3401, 16'h567F);
      push_update(KIND_ADD, 1'b0, 16'h007F, 16'h0001, 16'h0080);
      push_update(KIND_LOGIC, 1'b1, 16'hF0F0, 16'h0F0F, 16'h8000);
      push_update(KIND_SPARE, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
      push_update(KIND_ADD, 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
      push_access(MODE_READ, R_FLAGS, PART_HIGH, 16'h0000);

      repeat (N_RANDOM) access_queue.push_back(random_req());

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && !(access_queue.size() == 0 && !start && pending_rsp.size() == 0)) begin
         @(negedge clock);
         timed_out = (idle_cycles >= IDLE_LIMIT);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      if (timed_out)
         $display("Run stopped: %0d cycles without a transaction", IDLE_LIMIT);
      if (pending_rsp.size() != 0) begin
         mismatches += pending_rsp.size();
         $display("%0d expected results never arrived", pending_rsp.size());
      end
      $display("Covered %0d transactions: %0d writes, %0d reads, %0d flag updates, %0d refused.",
               n_sent, n_writes, n_reads, n_updates, n_refused);
      $display("%0d results checked, %0d field mismatches.", n_done, mismatches);
      if (mismatches == 0 && !timed_out)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
